// ----- hw/rtl/lcu_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the load-and-call instruction unit: item operation
// codes, opcodes, reset values and the default memory size. No dependencies.
package lcu_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  // Item operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // Architectural reset values and addressing constants
  localparam logic [15:0] PC_RESET   = 16'hFFFC;
  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [7:0]  ZP_MASK    = 8'hFF;

  // Supported opcodes
  localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
  localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OPC_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
  localparam logic [7:0] OPC_LDA_ABX = 8'hBD;
  localparam logic [7:0] OPC_LDA_ABY = 8'hB9;
  localparam logic [7:0] OPC_LDA_IZX = 8'hA1;
  localparam logic [7:0] OPC_LDA_IZY = 8'hB1;
  localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
  localparam logic [7:0] OPC_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
  localparam logic [7:0] OPC_LDY_ZP  = 8'hA4;
  localparam logic [7:0] OPC_JSR     = 8'h20;

endpackage

// ----- hw/rtl/lcu_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and result items.
// No dependencies.
interface lcu_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, operation, address, data, input ready);
  modport sink   (input valid, operation, address, data, output ready);
endinterface

interface lcu_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] program_counter;
  logic [7:0]  accumulator;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  stack_pointer;
  logic        zero_flag;
  logic        negative_flag;
  logic        fault;

  modport source (output valid, program_counter, accumulator, index_x, index_y,
                  stack_pointer, zero_flag, negative_flag, fault, input ready);
  modport sink   (input valid, program_counter, accumulator, index_x, index_y,
                  stack_pointer, zero_flag, negative_flag, fault, output ready);
endinterface

// ----- hw/rtl/lcu_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module lcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/load_and_call_instruction_unit.sv -----
`timescale 1ns / 1ps
// Load-and-call instruction unit. The time from command accept to result valid
// is set by the number of accesses the item makes to the single-port byte RAM
// and by back-pressure on the result. One item at a time; the unit is ready for
// the next command once the result is registered. Reset and a reset item sweep
// the RAM to zero, one byte a cycle, over all MEM_BYTES addresses, during which
// no command is accepted.
module load_and_call_instruction_unit #(
  parameter int MEM_BYTES = lcu_pkg::MEM_BYTES_DEF
) (
  input logic    clk,
  input logic    rst,
  lcu_cmd_if.sink   cmd,
  lcu_res_if.source res
);
  import lcu_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_OPC, ST_OPR1, ST_OPR2, ST_PTRLO, ST_PTRHI,
    ST_PTRDONE, ST_RDV, ST_LOADV, ST_PUSHH, ST_PUSHL, ST_FINISH
  } state_t;

  state_t state;

  // Architectural registers
  logic [15:0] pc;
  logic [7:0]  sp, acc, xr, yr;
  logic        zf, nf, flt;

  // Instruction working registers
  logic [7:0]  op_q;
  logic [7:0]  lo_q;
  logic [15:0] ea;

  // Clearing sweep
  logic [AW-1:0] clr_cnt;
  logic          report;

  // Result register
  logic        res_valid;
  logic [15:0] res_pc;
  logic [7:0]  res_acc, res_x, res_y, res_sp;
  logic        res_z, res_n, res_flt;

  // RAM port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [15:0]   addr16;

  logic        cmd_acc;
  logic [15:0] pc_m1;
  logic [15:0] word;
  logic        clr_last;
  logic        load_now;
  logic        dest_x, dest_y;

  // Fold a 16-bit address into the RAM by repeated compare and subtract;
  // the quotient is below 256 when MEM_BYTES is at least 256, so eight steps cover every case.
  function automatic logic [AW-1:0] reduce_addr(input logic [15:0] a);
    logic [23:0] r;
    logic [23:0] m;
    r = {8'd0, a};
    for (int k = 7; k >= 0; k--) begin
      m = 24'(MEM_BYTES) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic is_supported(input logic [7:0] o);
    case (o)
      OPC_LDA_IMM, OPC_LDA_ZP, OPC_LDA_ZPX, OPC_LDA_ABS, OPC_LDA_ABX,
      OPC_LDA_ABY, OPC_LDA_IZX, OPC_LDA_IZY, OPC_LDX_IMM, OPC_LDX_ZP,
      OPC_LDY_IMM, OPC_LDY_ZP, OPC_JSR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_imm(input logic [7:0] o);
    return (o == OPC_LDA_IMM) || (o == OPC_LDX_IMM) || (o == OPC_LDY_IMM);
  endfunction

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign pc_m1     = pc - 16'd1;
  assign word      = {mem_rdata, lo_q};
  assign clr_last  = (clr_cnt == AW'(MEM_BYTES - 1));
  assign dest_x    = (op_q == OPC_LDX_IMM) || (op_q == OPC_LDX_ZP);
  assign dest_y    = (op_q == OPC_LDY_IMM) || (op_q == OPC_LDY_ZP);
  // Loaded byte is always the RAM read data: operand for immediates, else
  // the byte fetched at the effective address.
  assign load_now  = ((state == ST_OPR1) && is_imm(op_q)) || (state == ST_LOADV);

  // RAM address and write selection by sequencer step
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    addr16    = pc;
    case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        if (cmd_acc && (cmd.operation == OP_WRITE)) begin
          mem_we    = 1'b1;
          addr16    = cmd.address;
          mem_wdata = cmd.data;
        end
      end
      ST_RDV, ST_PTRLO, ST_PTRHI: addr16 = ea;
      ST_PUSHH: begin
        mem_we    = 1'b1;
        addr16    = {STACK_PAGE, sp};
        mem_wdata = pc_m1[15:8];
      end
      ST_PUSHL: begin
        mem_we    = 1'b1;
        addr16    = {STACK_PAGE, sp};
        mem_wdata = pc_m1[7:0];
      end
      default: ;
    endcase
    mem_addr = (state == ST_CLEAR) ? clr_cnt : reduce_addr(addr16);
  end

  lcu_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      report    <= 1'b0;
      res_valid <= 1'b0;
      pc        <= PC_RESET;
      sp        <= SP_RESET;
      acc       <= '0;
      xr        <= '0;
      yr        <= '0;
      zf        <= 1'b0;
      nf        <= 1'b0;
      flt       <= 1'b0;
    end else begin
      // Drop a taken result, unless the finishing step reloads the slot
      if (res.valid && res.ready && (state != ST_FINISH)) begin
        res_valid <= 1'b0;
      end

      // Loads write the destination and the flags from the read data
      if (load_now) begin
        zf <= (mem_rdata == 8'd0);
        nf <= mem_rdata[7];
        if (dest_x) begin
          xr <= mem_rdata;
        end else if (dest_y) begin
          yr <= mem_rdata;
        end else begin
          acc <= mem_rdata;
        end
      end

      case (state)
        ST_CLEAR: begin
          // Sweep the RAM to zero, then report a pending reset item
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_last) begin
            state  <= report ? ST_FINISH : ST_IDLE;
            report <= 1'b0;
          end
        end

        ST_IDLE: begin
          if (cmd_acc) begin
            flt <= 1'b0;
            case (cmd.operation)
              OP_WRITE: state <= ST_FINISH;
              OP_EXEC: begin
                // Opcode read issued at pc this cycle
                pc    <= pc + 16'd1;
                state <= ST_OPC;
              end
              OP_RESET: begin
                pc      <= PC_RESET;
                sp      <= SP_RESET;
                acc     <= '0;
                xr      <= '0;
                yr      <= '0;
                zf      <= 1'b0;
                nf      <= 1'b0;
                clr_cnt <= '0;
                report  <= 1'b1;
                state   <= ST_CLEAR;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end

        ST_OPC: begin
          op_q <= mem_rdata;
          if (is_supported(mem_rdata)) begin
            // Every supported opcode takes at least one operand byte
            pc    <= pc + 16'd1;
            state <= ST_OPR1;
          end else begin
            flt   <= 1'b1;
            state <= ST_FINISH;
          end
        end

        ST_OPR1: begin
          case (op_q)
            OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM: state <= ST_FINISH;
            OPC_LDA_ZP, OPC_LDX_ZP, OPC_LDY_ZP: begin
              ea    <= {8'd0, mem_rdata};
              state <= ST_RDV;
            end
            OPC_LDA_ZPX: begin
              ea    <= {8'd0, mem_rdata + xr};
              state <= ST_RDV;
            end
            OPC_LDA_IZX: begin
              ea    <= {8'd0, mem_rdata + xr};
              state <= ST_PTRLO;
            end
            OPC_LDA_IZY: begin
              ea    <= {8'd0, mem_rdata};
              state <= ST_PTRLO;
            end
            default: begin
              // Absolute modes and JSR: fetch the high operand byte
              lo_q  <= mem_rdata;
              pc    <= pc + 16'd1;
              state <= ST_OPR2;
            end
          endcase
        end

        ST_OPR2: begin
          case (op_q)
            OPC_LDA_ABX: begin
              ea    <= word + {8'd0, xr};
              state <= ST_RDV;
            end
            OPC_LDA_ABY: begin
              ea    <= word + {8'd0, yr};
              state <= ST_RDV;
            end
            OPC_JSR: begin
              // Hold the target until both return bytes are pushed
              ea    <= word;
              state <= ST_PUSHH;
            end
            default: begin
              ea    <= word;
              state <= ST_RDV;
            end
          endcase
        end

        ST_PTRLO: begin
          // Pointer low byte read issued; second byte wraps in page zero
          ea    <= {8'd0, (ea[7:0] + 8'd1) & ZP_MASK};
          state <= ST_PTRHI;
        end

        ST_PTRHI: begin
          lo_q  <= mem_rdata;
          state <= ST_PTRDONE;
        end

        ST_PTRDONE: begin
          if (op_q == OPC_LDA_IZY) begin
            ea <= word + {8'd0, yr};
          end else begin
            ea <= word;
          end
          state <= ST_RDV;
        end

        ST_RDV: state <= ST_LOADV;

        ST_LOADV: state <= ST_FINISH;

        ST_PUSHH: begin
          sp    <= sp - 8'd1;
          state <= ST_PUSHL;
        end

        ST_PUSHL: begin
          sp    <= sp - 8'd1;
          pc    <= ea;
          state <= ST_FINISH;
        end

        ST_FINISH: begin
          // Register the result once the output slot is free
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_pc    <= pc;
            res_acc   <= acc;
            res_x     <= xr;
            res_y     <= yr;
            res_sp    <= sp;
            res_z     <= zf;
            res_n     <= nf;
            res_flt   <= flt;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid           = res_valid;
  assign res.program_counter = res_pc;
  assign res.accumulator     = res_acc;
  assign res.index_x         = res_x;
  assign res.index_y         = res_y;
  assign res.stack_pointer   = res_sp;
  assign res.zero_flag       = res_z;
  assign res.negative_flag   = res_n;
  assign res.fault           = res_flt;

endmodule

// ----- hw/rtl/lcu_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the load-and-call instruction unit, with the bind
// that attaches them. Depends on lcu_pkg.
module lcu_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [1:0]  cmd_operation,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_program_counter,
  input logic        res_fault
);
  import lcu_pkg::*;

  // Reset starts the clearing sweep: no command is taken right after it
  a_rst_busy: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command ready right after reset");

  // One item at a time: the unit is busy in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command ready in the cycle after an accept");

  // A reset item starts the sweep, so no result appears in the next cycle
  // unless one was already waiting
  a_reset_item: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd_operation == OP_RESET) && !res_valid)
      |=> !res_valid)
    else $error("result raised right after a reset item");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_program_counter) && $stable(res_fault)))
    else $error("stalled result changed");

endmodule

bind load_and_call_instruction_unit lcu_checker u_lcu_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cmd_valid           (cmd.valid),
  .cmd_ready           (cmd.ready),
  .cmd_operation       (cmd.operation),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .res_program_counter (res.program_counter),
  .res_fault           (res.fault)
);

// ----- tb/load_and_call_instruction_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for load_and_call_instruction_unit: drives command items,
// mirrors the CPU state in a local model and compares every result item.
// Depends on lcu_pkg, lcu_if.sv and the unit itself.
module load_and_call_instruction_unit_test;
  import lcu_pkg::*;

  localparam int          MEM_SIZE    = MEM_BYTES_DEF;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          ITEM_TARGET = 1800;
  // Operation code three is unused by the unit: it must report state unchanged
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef enum logic [1:0] {DST_NONE, DST_ACC, DST_X, DST_Y} load_dst_t;

  // Architectural snapshot carried by one result item
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic        z;
    logic        n;
    logic        fault;
  } cpu_view_t;

  logic clk = 1'b0;
  logic rst;

  lcu_cmd_if cmd ();
  lcu_res_if res ();

  load_and_call_instruction_unit u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the CPU: byte image, registers and flags
  // ---------------------------------------------------------------------------
  logic [7:0]  mem_img [0:MEM_SIZE-1];
  logic [15:0] cpu_pc;
  logic [7:0]  cpu_sp, cpu_a, cpu_x, cpu_y;
  logic        cpu_z, cpu_n;

  cpu_view_t   expected_views [$];
  int          error_count = 0;
  int          sent_items  = 0;
  int          cycle_count = 0;
  int          resets_left = 3;
  bit          idle_enable = 1'b1;

  function automatic logic [7:0] peek(logic [15:0] a);
    return mem_img[int'(a) % MEM_SIZE];
  endfunction

  function automatic void poke(logic [15:0] a, logic [7:0] v);
    mem_img[int'(a) % MEM_SIZE] = v;
  endfunction

  function automatic void clear_cpu();
    foreach (mem_img[i]) mem_img[i] = 8'h00;
    cpu_pc = PC_RESET;
    cpu_sp = SP_RESET;
    cpu_a  = 8'h00;
    cpu_x  = 8'h00;
    cpu_y  = 8'h00;
    cpu_z  = 1'b0;
    cpu_n  = 1'b0;
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] v;
    v      = peek(cpu_pc);
    cpu_pc = cpu_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [7:0] lo, hi;
    lo = fetch_byte();
    hi = fetch_byte();
    return {hi, lo};
  endfunction

  // Pointer in page zero; the high byte wraps within the page
  function automatic logic [15:0] zp_word(logic [7:0] zp);
    logic [7:0] zp1;
    zp1 = zp + 8'd1;
    return {peek({8'h00, zp1}), peek({8'h00, zp})};
  endfunction

  // Execute one instruction at PC; returns 0 for an unhandled opcode
  function automatic bit step_cpu();
    logic [7:0]  opc, v, zp;
    logic [15:0] ea, target, ret;
    load_dst_t   dst;
    bit          ok;
    ok  = 1'b1;
    dst = DST_NONE;
    v   = 8'h00;
    opc = fetch_byte();
    case (opc)
      OPC_LDA_IMM: begin v = fetch_byte(); dst = DST_ACC; end
      OPC_LDA_ZP: begin
        zp = fetch_byte(); v = peek({8'h00, zp}); dst = DST_ACC;
      end
      OPC_LDA_ZPX: begin
        zp = fetch_byte() + cpu_x; v = peek({8'h00, zp}); dst = DST_ACC;
      end
      OPC_LDA_ABS: begin v = peek(fetch_word()); dst = DST_ACC; end
      OPC_LDA_ABX: begin
        ea = fetch_word() + {8'h00, cpu_x}; v = peek(ea); dst = DST_ACC;
      end
      OPC_LDA_ABY: begin
        ea = fetch_word() + {8'h00, cpu_y}; v = peek(ea); dst = DST_ACC;
      end
      OPC_LDA_IZX: begin
        zp = fetch_byte() + cpu_x; v = peek(zp_word(zp)); dst = DST_ACC;
      end
      OPC_LDA_IZY: begin
        zp = fetch_byte(); ea = zp_word(zp) + {8'h00, cpu_y};
        v = peek(ea); dst = DST_ACC;
      end
      OPC_LDX_IMM: begin v = fetch_byte(); dst = DST_X; end
      OPC_LDX_ZP: begin zp = fetch_byte(); v = peek({8'h00, zp}); dst = DST_X; end
      OPC_LDY_IMM: begin v = fetch_byte(); dst = DST_Y; end
      OPC_LDY_ZP: begin zp = fetch_byte(); v = peek({8'h00, zp}); dst = DST_Y; end
      OPC_JSR: begin
        target = fetch_word();
        ret    = cpu_pc - 16'd1;
        poke({STACK_PAGE, cpu_sp}, ret[15:8]);
        cpu_sp = cpu_sp - 8'd1;
        poke({STACK_PAGE, cpu_sp}, ret[7:0]);
        cpu_sp = cpu_sp - 8'd1;
        cpu_pc = target;
      end
      default: ok = 1'b0;
    endcase
    if (dst != DST_NONE) begin
      cpu_z = (v == 8'h00);
      cpu_n = v[7];
      case (dst)
        DST_ACC: cpu_a = v;
        DST_X:   cpu_x = v;
        default: cpu_y = v;
      endcase
    end
    return ok;
  endfunction

  // Apply one accepted command item and return the snapshot the unit should report
  function automatic cpu_view_t apply_item(logic [1:0] op, logic [15:0] addr,
                                           logic [7:0] dat);
    cpu_view_t r;
    logic      flt;
    flt = 1'b0;
    case (op)
      OP_WRITE: poke(addr, dat);
      OP_EXEC:  flt = !step_cpu();
      OP_RESET: clear_cpu();
      default: ;
    endcase
    r.pc    = cpu_pc;
    r.acc   = cpu_a;
    r.x     = cpu_x;
    r.y     = cpu_y;
    r.sp    = cpu_sp;
    r.z     = cpu_z;
    r.n     = cpu_n;
    r.fault = flt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field comparison
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    cpu_view_t w;
    if (res.valid && res.ready) begin
      if (expected_views.size() == 0) begin
        $error("result item arrived with no expectation pending");
        error_count++;
      end else begin
        w = expected_views.pop_front();
        check_field("program_counter", 32'(w.pc),    32'(res.program_counter));
        check_field("accumulator",     32'(w.acc),   32'(res.accumulator));
        check_field("index_x",         32'(w.x),     32'(res.index_x));
        check_field("index_y",         32'(w.y),     32'(res.index_y));
        check_field("stack_pointer",   32'(w.sp),    32'(res.stack_pointer));
        check_field("zero_flag",       32'(w.z),     32'(res.zero_flag));
        check_field("negative_flag",   32'(w.n),     32'(res.negative_flag));
        check_field("fault",           32'(w.fault), 32'(res.fault));
      end
    end
    // Stall with a chance of 7 in a hundred unless idling is switched off
    res.ready <= !(idle_enable && $urandom_range(0, 99) < 7);
  end

  // Guard against a hung handshake; the limit covers several RAM clearing sweeps
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until accepted, then record what it should produce.
  // Valid stays high after acceptance so that back-to-back items need no gap.
  task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] dat);
    while (idle_enable && $urandom_range(0, 99) < 7) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.operation <= op;
    cmd.address   <= addr;
    cmd.data      <= dat;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    expected_views.push_back(apply_item(op, addr, dat));
    sent_items++;
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  // Place one instruction at PC with random operands, seed its pointer and
  // operand bytes where it has any, then execute it
  task automatic run_instruction(input logic [7:0] opc);
    logic [15:0] base, ea;
    logic [7:0]  b1, b2, zp, zp1, lo, hi, val;
    bit          has_ea;
    base   = cpu_pc;
    b1     = 8'($urandom);
    b2     = 8'($urandom);
    has_ea = 1'b1;
    ea     = 16'h0000;
    // Now and then aim a call at the last page so that later fetches may wrap PC
    if (opc == OPC_JSR && $urandom_range(0, 15) == 0) b2 = 8'hFF;
    send_item(OP_WRITE, base, opc);
    send_item(OP_WRITE, base + 16'd1, b1);
    send_item(OP_WRITE, base + 16'd2, b2);
    case (opc)
      OPC_LDA_ZP, OPC_LDX_ZP, OPC_LDY_ZP: ea = {8'h00, b1};
      OPC_LDA_ZPX: begin
        zp = b1 + cpu_x;
        ea = {8'h00, zp};
      end
      OPC_LDA_ABS: ea = {b2, b1};
      OPC_LDA_ABX: ea = {b2, b1} + {8'h00, cpu_x};
      OPC_LDA_ABY: ea = {b2, b1} + {8'h00, cpu_y};
      OPC_LDA_IZX, OPC_LDA_IZY: begin
        if (opc == OPC_LDA_IZX) zp = b1 + cpu_x;
        else zp = b1;
        zp1 = zp + 8'd1;
        lo  = 8'($urandom);
        hi  = 8'($urandom);
        send_item(OP_WRITE, {8'h00, zp}, lo);
        send_item(OP_WRITE, {8'h00, zp1}, hi);
        ea = {hi, lo};
        if (opc == OPC_LDA_IZY) ea = ea + {8'h00, cpu_y};
      end
      default: has_ea = 1'b0;
    endcase
    // Bias operand values towards zero and negative to work both flags
    if (has_ea && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       val = 8'h00;
        1:       val = 8'h80 | 8'($urandom);
        default: val = 8'($urandom);
      endcase
      send_item(OP_WRITE, ea, val);
    end
    // Address and data are don't-care for execute; randomise them anyway
    send_item(OP_EXEC, 16'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the cleared RAM yields opcode zero: expect a fault
  // with PC stepped past it, then an unused operation that changes nothing
  task automatic test_power_on();
    send_item(OP_EXEC, 16'h0000, 8'h00);
    send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
  endtask

  // Write both ends of the address and data ranges
  task automatic test_write_extremes();
    send_item(OP_WRITE, 16'hFFFF, 8'hFF);
    send_item(OP_WRITE, 16'h0000, 8'h00);
  endtask

  // A call whose operand fetch wraps PC to zero, so the pushed return
  // address is 0xFFFF
  task automatic test_call_wrap();
    send_item(OP_WRITE, cpu_pc, OPC_JSR);
    send_item(OP_WRITE, 16'hFFFE, 8'h00);
    send_item(OP_WRITE, 16'hFFFF, 8'h80);
    send_item(OP_EXEC, 16'h1234, 8'h5A);
  endtask

  // With X at 0xFF: zero-page index wraps, (zp,X) pointer wraps, (zp),Y high
  // pointer byte wraps within page zero and absolute+X wraps at 16 bits
  task automatic test_index_wrap();
    logic [15:0] p;
    p = cpu_pc;
    send_item(OP_WRITE, p,          OPC_LDX_IMM);
    send_item(OP_WRITE, p + 16'd1,  8'hFF);
    send_item(OP_EXEC,  16'h0000,   8'h00);
    send_item(OP_WRITE, p + 16'd2,  OPC_LDA_ZPX);
    send_item(OP_WRITE, p + 16'd3,  8'h01);
    send_item(OP_EXEC,  16'h0000,   8'h00);
    send_item(OP_WRITE, p + 16'd4,  OPC_LDA_IZX);
    send_item(OP_WRITE, p + 16'd5,  8'h01);
    send_item(OP_EXEC,  16'h0000,   8'h00);
    send_item(OP_WRITE, p + 16'd6,  OPC_LDA_IZY);
    send_item(OP_WRITE, p + 16'd7,  8'hFF);
    send_item(OP_EXEC,  16'h0000,   8'h00);
    send_item(OP_WRITE, p + 16'd8,  OPC_LDA_ABX);
    send_item(OP_WRITE, p + 16'd9,  8'hFF);
    send_item(OP_WRITE, p + 16'd10, 8'hFF);
    send_item(OP_EXEC,  16'h0000,   8'h00);
  endtask

  // A reset item restores every register and sweeps the RAM
  task automatic test_core_reset();
    send_item(OP_RESET, 16'hA5A5, 8'h5A);
  endtask

  // A long run of nested calls walks SP down through page one, with idling
  // switched off on both sides; enough calls would carry SP past its wrap
  task automatic test_call_chain();
    idle_enable = 1'b0;
    for (int i = 0; i < 140; i++) begin
      if ($urandom_range(0, 4) != 0) run_instruction(OPC_JSR);
      else run_instruction(OPC_LDA_IMM);
    end
    idle_enable = 1'b1;
  endtask

  // Mostly well-formed instructions with random content; the rest is stray
  // items, random opcodes and the odd core reset
  task automatic test_mixed_random();
    logic [7:0] opc_set [13];
    int         r;
    opc_set = '{OPC_LDA_IMM, OPC_LDA_ZP, OPC_LDA_ZPX, OPC_LDA_ABS, OPC_LDA_ABX,
                OPC_LDA_ABY, OPC_LDA_IZX, OPC_LDA_IZY, OPC_LDX_IMM, OPC_LDX_ZP,
                OPC_LDY_IMM, OPC_LDY_ZP, OPC_JSR};
    // Let the pipeline empty once before starting
    drain_results();
    while (sent_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        run_instruction(opc_set[$urandom_range(0, 12)]);
      end else if (r < 92) begin
        run_instruction(8'($urandom));
      end else if (r < 99) begin
        case ($urandom_range(0, 2))
          0:       send_item(OP_WRITE, 16'($urandom), 8'($urandom));
          1:       send_item(OP_EXEC, 16'($urandom), 8'($urandom));
          default: send_item(OP_UNUSED, 16'($urandom), 8'($urandom));
        endcase
      end else if (resets_left > 0) begin
        resets_left--;
        send_item(OP_RESET, 16'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    cmd.valid     <= 1'b0;
    cmd.operation <= OP_WRITE;
    cmd.address   <= 16'h0000;
    cmd.data      <= 8'h00;
    clear_cpu();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_write_extremes();
    test_call_wrap();
    test_index_wrap();
    test_core_reset();
    test_call_chain();
    test_mixed_random();

    // Hold valid low, wait out the last results, then allow the longest
    // instruction latency to show up any stray item
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
